>>> rtl/tloi_pkg.sv
// Shared types, constants and codes for the text line offset indexer.
// No dependencies; every other file in this folder imports it.
`timescale 1ns / 1ps

package tloi_pkg;

  // Width of the byte offsets kept internally; outputs are always OUT_W bits.
  localparam int OFFSET_BITS = 32;
  localparam int POS_W       = (OFFSET_BITS < 32) ? OFFSET_BITS : 32;
  localparam int OUT_W       = 32;

  // Records produced by one input item, at most.
  localparam int MAX_RECS = 4;
  localparam int CNT_W    = $clog2(MAX_RECS + 1);
  localparam int IDX_W    = $clog2(MAX_RECS);

  typedef logic [POS_W-1:0] pos_t;
  localparam pos_t POS_LIMIT = '1;

  // Input item kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_EOF  = 1'b1;

  // Record kinds
  localparam logic REC_LINE    = 1'b0;
  localparam logic REC_SUMMARY = 1'b1;

  // Line ending widths
  localparam logic [1:0] EW_NONE  = 2'd0;
  localparam logic [1:0] EW_BYTE  = 2'd1;
  localparam logic [1:0] EW_UTF16 = 2'd2;

  // Encodings
  localparam logic ENC_UTF8  = 1'b0;
  localparam logic ENC_UTF16 = 1'b1;

  // Content start offsets
  localparam logic [1:0] CS_NONE  = 2'd0;
  localparam logic [1:0] CS_UTF16 = 2'd2;
  localparam logic [1:0] CS_UTF8  = 2'd3;

  // Byte values of interest
  localparam logic [7:0] BOM8_B0  = 8'hEF;
  localparam logic [7:0] BOM8_B1  = 8'hBB;
  localparam logic [7:0] BOM8_B2  = 8'hBF;
  localparam logic [7:0] BOM16_B0 = 8'hFF;
  localparam logic [7:0] BOM16_B1 = 8'hFE;
  localparam logic [7:0] NEWLINE  = 8'h0A;
  localparam logic [7:0] NUL      = 8'h00;

  typedef struct packed {
    logic       record_kind;
    pos_t       line_start;
    pos_t       line_end;
    logic [1:0] ending_width;
    logic       encoding;
    logic [1:0] content_start;
    logic       overflow;
  } rec_t;

  typedef struct packed {
    logic [CNT_W-1:0]     count;
    rec_t [MAX_RECS-1:0]  recs;
  } batch_t;

endpackage

>>> rtl/text_line_offset_indexer.sv
// Top level of the text line offset indexer: scanner plus result buffer.
// Depends on tloi_pkg, tloi_scan and tloi_outbuf.
`timescale 1ns / 1ps

// Stream a file in one byte per transfer (kind 0), then one end marker
// (kind 1). The block watches the first three bytes for a byte order mark:
// EF BB BF means UTF-8 with content from offset 3, FF FE means UTF-16LE with
// content from offset 2, anything else is byte text from offset 0. In byte
// mode every 0A closes a line; in UTF-16 mode only an aligned 0A 00 unit does.
// Each line record carries start and end offsets and the width of its ending;
// the end marker adds a record for an unterminated tail and a summary that
// gives the content start and the file length, then clears all state so the
// next byte begins a new file. Offsets saturate at all ones and set the
// sticky overflow flag. Each input transfer is worked in a single pass from
// the state registers into a four-entry result buffer, so one byte is taken
// per cycle unless output stalls; an item that yields k records holds the
// input until the buffer, draining one record per output transfer, hands
// out the last. Only the third header byte (up to three records) and the
// end marker (up to three) can yield more than one. Items are accepted when
// the buffer is empty or is handing out its last record in that cycle.
module text_line_offset_indexer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Input channel
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      kind_i,
  input  logic [7:0]                data_byte_i,
  // Result channel
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      record_kind_o,
  output logic [tloi_pkg::OUT_W-1:0] line_start_o,
  output logic [tloi_pkg::OUT_W-1:0] line_end_o,
  output logic [1:0]                ending_width_o,
  output logic                      encoding_o,
  output logic [1:0]                content_start_o,
  output logic                      overflow_o,
  output logic                      last_of_run_o
);
  import tloi_pkg::*;

  batch_t batch;
  rec_t   rec;
  logic   can_load;
  logic   in_xfer;

  // Take a transfer only when the buffer can hold its whole batch.
  assign in_stall_o = !can_load;
  assign in_xfer    = in_valid_i && can_load;

  tloi_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_xfer),
    .kind_i      (kind_i),
    .data_byte_i (data_byte_i),
    .batch_o     (batch)
  );

  tloi_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_xfer),
    .batch_i     (batch),
    .out_stall_i (out_stall_i),
    .can_load_o  (can_load),
    .valid_o     (out_valid_o),
    .rec_o       (rec),
    .last_o      (last_of_run_o)
  );

  // Widen internal offsets to the port width.
  assign record_kind_o   = rec.record_kind;
  assign line_start_o    = OUT_W'(rec.line_start);
  assign line_end_o      = OUT_W'(rec.line_end);
  assign ending_width_o  = rec.ending_width;
  assign encoding_o      = rec.encoding;
  assign content_start_o = rec.content_start;
  assign overflow_o      = rec.overflow;

endmodule

>>> rtl/tloi_scan.sv
// Scanner: file state registers plus the single-pass logic that turns one
// input transfer into a batch of up to four records. Depends on tloi_pkg.
`timescale 1ns / 1ps

module tloi_scan (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic            kind_i,
  input  logic [7:0]      data_byte_i,
  output tloi_pkg::batch_t batch_o
);
  import tloi_pkg::*;

  localparam int HDR_LEN = 3;

  logic [1:0] hcnt_q, hcnt_d;
  logic [7:0] hb_q [2];
  logic [7:0] hb_d [2];
  logic       utf16_q, utf16_d;
  logic [1:0] start_q, start_d;
  pos_t       pos_q, pos_d;
  pos_t       cls_q, cls_d;
  logic [7:0] pend_q, pend_d;
  logic       phase_q, phase_d;
  logic       sat_q, sat_d;

  batch_t           bat;
  logic [CNT_W-1:0] n;
  logic             enc_v;
  logic [1:0]       cs_v;
  pos_t             cls_v;
  pos_t             low_v;
  logic [1:0]       hdr_n;
  logic [7:0]       hdr [HDR_LEN];

  function automatic rec_t make_rec(logic kind, pos_t s, pos_t e, logic [1:0] w,
                                    logic enc, logic [1:0] cs, logic ovf);
    rec_t r;
    r.record_kind   = kind;
    r.line_start    = s;
    r.line_end      = e;
    r.ending_width  = w;
    r.encoding      = enc;
    r.content_start = cs;
    r.overflow      = ovf;
    return r;
  endfunction

  function automatic pos_t sat_inc(pos_t a);
    return (a == POS_LIMIT) ? POS_LIMIT : a + pos_t'(1);
  endfunction

  function automatic pos_t sat_add2(pos_t a);
    return (a >= POS_LIMIT - pos_t'(1)) ? POS_LIMIT : a + pos_t'(2);
  endfunction

  always_comb begin
    hcnt_d  = hcnt_q;
    hb_d    = hb_q;
    utf16_d = utf16_q;
    start_d = start_q;
    pos_d   = pos_q;
    cls_d   = cls_q;
    pend_d  = pend_q;
    phase_d = phase_q;
    sat_d   = sat_q;
    bat     = '0;
    n       = '0;
    enc_v   = utf16_q;
    cs_v    = start_q;
    cls_v   = cls_q;
    low_v   = '0;
    hdr_n   = 2'd0;
    hdr[0]  = hb_q[0];
    hdr[1]  = hb_q[1];
    hdr[2]  = data_byte_i;

    if (kind_i == KIND_DATA) begin
      if (hcnt_q != 2'(HDR_LEN)) begin
        // Hold header bytes; the third one resolves the mark on arrival.
        if (hcnt_q < 2'd2) begin
          hb_d[hcnt_q[0]] = data_byte_i;
        end
        hcnt_d = hcnt_q + 2'd1;
        if (hcnt_q == 2'd2) begin
          if (hb_q[0] == BOM8_B0 && hb_q[1] == BOM8_B1 && data_byte_i == BOM8_B2) begin
            enc_v = ENC_UTF8;
            cs_v  = CS_UTF8;
          end else if (hb_q[0] == BOM16_B0 && hb_q[1] == BOM16_B1) begin
            enc_v   = ENC_UTF16;
            cs_v    = CS_UTF16;
            pend_d  = data_byte_i;
            phase_d = 1'b1;
          end else begin
            enc_v = ENC_UTF8;
            cs_v  = CS_NONE;
            hdr_n = 2'(HDR_LEN);
          end
          cls_v = pos_t'(cs_v);
        end
      end else if (utf16_q == ENC_UTF8) begin
        if (data_byte_i == NEWLINE) begin
          bat.recs[n[IDX_W-1:0]] = make_rec(REC_LINE, cls_q, pos_q, EW_BYTE,
                                            enc_v, cs_v, sat_q);
          n     = n + CNT_W'(1);
          cls_v = sat_inc(pos_q);
        end
      end else if (!phase_q) begin
        pend_d  = data_byte_i;
        phase_d = 1'b1;
      end else begin
        phase_d = 1'b0;
        if (pend_q == NEWLINE && data_byte_i == NUL) begin
          // Line end points at the low byte of the code unit.
          low_v = sat_q ? POS_LIMIT : pos_q - pos_t'(1);
          bat.recs[n[IDX_W-1:0]] = make_rec(REC_LINE, cls_q, low_v, EW_UTF16,
                                            enc_v, cs_v, sat_q);
          n     = n + CNT_W'(1);
          cls_v = sat_add2(low_v);
        end
      end
      if (pos_q == POS_LIMIT) begin
        sat_d = 1'b1;
      end else begin
        pos_d = pos_q + pos_t'(1);
      end
    end else begin
      // Short file: resolve with what was held.
      if (hcnt_q != 2'(HDR_LEN)) begin
        if (hcnt_q == 2'd2 && hb_q[0] == BOM16_B0 && hb_q[1] == BOM16_B1) begin
          enc_v = ENC_UTF16;
          cs_v  = CS_UTF16;
        end else begin
          enc_v = ENC_UTF8;
          cs_v  = CS_NONE;
          hdr_n = hcnt_q;
        end
        cls_v = pos_t'(cs_v);
      end
    end

    // Byte-mode scan of held header bytes.
    for (int i = 0; i < HDR_LEN; i++) begin
      if (2'(i) < hdr_n && hdr[i] == NEWLINE) begin
        bat.recs[n[IDX_W-1:0]] = make_rec(REC_LINE, cls_v, pos_t'(i), EW_BYTE,
                                          enc_v, cs_v, sat_q);
        n     = n + CNT_W'(1);
        cls_v = pos_t'(i + 1);
      end
    end

    if (kind_i == KIND_EOF) begin
      if (pos_q > cls_v) begin
        bat.recs[n[IDX_W-1:0]] = make_rec(REC_LINE, cls_v, pos_q, EW_NONE,
                                          enc_v, cs_v, sat_q);
        n = n + CNT_W'(1);
      end
      bat.recs[n[IDX_W-1:0]] = make_rec(REC_SUMMARY, pos_t'(cs_v), pos_q, EW_NONE,
                                        enc_v, cs_v, sat_q);
      n = n + CNT_W'(1);
      // Return to the reset state for the next file.
      hcnt_d  = 2'd0;
      utf16_d = ENC_UTF8;
      start_d = CS_NONE;
      pos_d   = '0;
      cls_d   = '0;
      pend_d  = '0;
      phase_d = 1'b0;
      sat_d   = 1'b0;
    end else begin
      utf16_d = enc_v;
      start_d = cs_v;
      cls_d   = cls_v;
    end

    bat.count = n;
  end

  assign batch_o = bat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hcnt_q  <= 2'd0;
      utf16_q <= ENC_UTF8;
      start_q <= CS_NONE;
      pos_q   <= '0;
      cls_q   <= '0;
      pend_q  <= '0;
      phase_q <= 1'b0;
      sat_q   <= 1'b0;
    end else if (accept_i) begin
      hcnt_q  <= hcnt_d;
      utf16_q <= utf16_d;
      start_q <= start_d;
      pos_q   <= pos_d;
      cls_q   <= cls_d;
      pend_q  <= pend_d;
      phase_q <= phase_d;
      sat_q   <= sat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      hb_q <= hb_d;
    end
  end

  a_eof_ends_with_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && kind_i == KIND_EOF |-> batch_o.count != '0 &&
      batch_o.recs[IDX_W'(batch_o.count - CNT_W'(1))].record_kind == REC_SUMMARY)
    else $error("end marker batch does not close with a summary");

  a_data_batch_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && kind_i == KIND_DATA |-> batch_o.count < CNT_W'(MAX_RECS))
    else $error("data byte produced too many records");

endmodule

>>> rtl/tloi_outbuf.sv
// Result buffer: registers one batch of records and presents them one per
// transfer, flagging the last of the batch. Depends on tloi_pkg.
`timescale 1ns / 1ps

module tloi_outbuf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  tloi_pkg::batch_t batch_i,
  input  logic             out_stall_i,
  output logic             can_load_o,
  output logic             valid_o,
  output tloi_pkg::rec_t   rec_o,
  output logic             last_o
);
  import tloi_pkg::*;

  rec_t [MAX_RECS-1:0] recs_q;
  logic [CNT_W-1:0]    count_q;
  logic [IDX_W-1:0]    idx_q;
  logic                take;

  assign valid_o    = (count_q != '0);
  assign rec_o      = recs_q[idx_q];
  assign last_o     = (CNT_W'(idx_q) + CNT_W'(1) == count_q);
  assign take       = valid_o && !out_stall_i;
  assign can_load_o = !valid_o || (take && last_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
    end else if (load_i) begin
      count_q <= batch_i.count;
      idx_q   <= '0;
    end else if (take) begin
      if (last_o) begin
        count_q <= '0;
        idx_q   <= '0;
      end else begin
        idx_q <= idx_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      recs_q <= batch_i.recs;
    end
  end

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != '0 |-> CNT_W'(idx_q) < count_q)
    else $error("record index past batch count");

  a_load_presents_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i && batch_i.count != '0 |=> valid_o && idx_q == '0)
    else $error("loaded batch not presented from its first record");

endmodule
